/* hw/rtl/dbsh_pkg.sv */
// Package: widths, codes and control/status structs for the histogram engine.
package dbsh_pkg;
	localparam int NumBins   = 2048;
	localparam int BinW      = $clog2(NumBins);
	localparam int CntW      = 24;
	localparam int SumW      = 56;
	localparam int MeanW     = 31;
	localparam int DiffW     = 33;
	localparam int CfgW      = 31;
	localparam int CfgIdxW   = 1;
	localparam logic [CntW-1:0] CountMax = '1;

	localparam logic [1:0] CmdClear = 2'd0;
	localparam logic [1:0] CmdAdd   = 2'd1;
	localparam logic [1:0] CmdRead  = 2'd2;

	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StSkip  = 2'd1;
	localparam logic [1:0] StAbove = 2'd2;
	localparam logic [1:0] StBelow = 2'd3;

	localparam logic [CfgIdxW-1:0] RegBinWidth  = 1'd0;
	localparam logic [CfgIdxW-1:0] RegThreshold = 1'd1;

	typedef struct packed {
		logic [1:0]       command;
		logic signed [31:0] upper_wavenumber;
		logic signed [31:0] lower_wavenumber;
		logic signed [15:0] amplitude;
		logic [10:0]      read_bin;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] bin_index;
		logic [23:0] bin_count;
		logic [30:0] mean_square;
		logic [10:0] lowest_bin;
		logic [10:0] highest_bin;
	} out_beat_t;

	typedef struct packed {
		logic load;       // capture input beat
		logic clr_start;  // start clearing sweep
		logic clr_step;   // clear one entry
		logic div_start;  // start bin division
		logic div_step;   // one quotient bit
		logic classify;   // decide bin and status
		logic mem_rd;     // issue store read
		logic mem_wr;     // write updated entry
		logic mean_start; // start mean division
		logic mean_step;  // one mean bit
		logic emit;       // load output register
	} ctrl_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic mean_done;
		logic is_clear;
		logic is_add;
		logic is_read;
		logic need_div;   // add beat not skipped
		logic in_range;   // bin valid for update/read
	} stat_t;
endpackage

/* hw/rtl/dbsh_if.sv */
// Interfaces: valid/ready channels for input and result beats.
interface dbsh_in_if;
	import dbsh_pkg::*;
	logic     valid;
	logic     ready;
	in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dbsh_out_if;
	import dbsh_pkg::*;
	logic      valid;
	logic      ready;
	out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dbsh_datapath.sv */
// Datapath: difference, serial binning divider, bin stores, serial mean divider.
module dbsh_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dbsh_pkg::ctrl_t                  ctrl,
	output dbsh_pkg::stat_t                  stat,
	input  dbsh_pkg::in_beat_t               in_data,
	input  logic [dbsh_pkg::CfgW-1:0]        bin_span,
	input  logic [dbsh_pkg::CfgW-1:0]        threshold,
	output dbsh_pkg::out_beat_t              result
);
	import dbsh_pkg::*;

	logic [CntW-1:0] count_mem [NumBins];
	logic [SumW-1:0] sum_mem   [NumBins];

	in_beat_t             beat_q;
	logic [DiffW-1:0]     mag_q;
	logic                 neg_q;
	logic [CfgW-1:0]      div_w_q;
	logic [DiffW-1:0]     quo_q;
	logic [CfgW:0]        rem_q;
	logic [5:0]           div_cnt_q;
	logic [BinW:0]        clr_q;
	logic [BinW-1:0]      bin_q;
	logic [1:0]           st_q;
	logic                 range_q;
	logic [CntW-1:0]      cnt_rd_q;
	logic [SumW-1:0]      sum_rd_q;
	logic [CntW-1:0]      cnt_new_q;
	logic [SumW-1:0]      sum_new_q;
	logic [SumW-1:0]      msum_q;
	logic [CntW:0]        mrem_q;
	logic [5:0]           mcnt_q;
	logic [BinW-1:0]      low_q;
	logic [BinW-1:0]      high_q;

	logic signed [DiffW-1:0] diff;
	logic [DiffW-1:0]        dmag;
	logic [CfgW:0]           rtry;
	logic [CntW:0]           mtry;
	logic [DiffW:0]          qfloor;
	logic signed [DiffW+1:0] binv;
	logic [BinW-1:0]         rd_addr;

	assign diff = DiffW'(in_data.upper_wavenumber) - DiffW'(in_data.lower_wavenumber);
	assign dmag = diff[DiffW-1] ? DiffW'(-diff) : diff;
	assign rtry = {rem_q[CfgW-1:0], quo_q[DiffW-1]};
	assign mtry = {mrem_q[CntW-1:0], msum_q[SumW-1]};
	// floor quotient magnitude: negative with remainder rounds away
	assign qfloor = (neg_q && rem_q != '0) ? {1'b0, quo_q} + 1'b1 : {1'b0, quo_q};
	assign binv = neg_q ? (DiffW+2)'(NumBins/2) - (DiffW+2)'(qfloor)
			: (DiffW+2)'(NumBins/2) + (DiffW+2)'(qfloor);
	assign rd_addr = beat_q.command == CmdRead ? beat_q.read_bin[BinW-1:0] : bin_q;

	assign stat.clr_done  = clr_q == (BinW+1)'(NumBins - 1);
	assign stat.div_done  = div_cnt_q == 6'(DiffW - 1);
	assign stat.mean_done = mcnt_q == 6'(SumW - 1);
	assign stat.is_clear  = beat_q.command == CmdClear;
	assign stat.is_add    = beat_q.command == CmdAdd;
	assign stat.is_read   = beat_q.command == CmdRead;
	assign stat.need_div  = st_q == StOk;
	assign stat.in_range  = range_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			beat_q  <= in_data;
			mag_q   <= dmag;
			neg_q   <= diff[DiffW-1];
			div_w_q <= (bin_span == '0) ? CfgW'(1) : bin_span;
			st_q    <= (in_data.command == CmdAdd && dmag <= DiffW'(threshold)) ? StSkip : StOk;
			range_q <= in_data.command == CmdRead;
		end
		if (ctrl.div_start) begin
			quo_q     <= mag_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (ctrl.div_step) begin
			if (rtry >= {1'b0, div_w_q}) begin
				rem_q <= rtry - {1'b0, div_w_q};
				quo_q <= {quo_q[DiffW-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[DiffW-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 6'd1;
		end
		if (ctrl.classify) begin
			bin_q <= binv[BinW-1:0];
			if (binv >= (DiffW+2)'(NumBins)) begin
				st_q <= StAbove; range_q <= 1'b0;
			end else if (binv < 0) begin
				st_q <= StBelow; range_q <= 1'b0;
			end else begin
				range_q <= 1'b1;
			end
		end
		if (ctrl.mem_rd) begin
			cnt_rd_q <= count_mem[rd_addr];
			sum_rd_q <= sum_mem[rd_addr];
		end
		if (ctrl.mean_start) begin
			if (stat.is_add && cnt_rd_q != CountMax) begin
				cnt_new_q <= cnt_rd_q + 1'b1;
				sum_new_q <= sum_rd_q + SumW'(32'(beat_q.amplitude * beat_q.amplitude));
				msum_q    <= sum_rd_q + SumW'(32'(beat_q.amplitude * beat_q.amplitude));
			end else begin
				cnt_new_q <= cnt_rd_q;
				sum_new_q <= sum_rd_q;
				msum_q    <= sum_rd_q;
			end
			mrem_q <= '0;
			mcnt_q <= '0;
		end else if (ctrl.mean_step) begin
			if (mtry >= {1'b0, cnt_new_q}) begin
				mrem_q <= mtry - {1'b0, cnt_new_q};
				msum_q <= {msum_q[SumW-2:0], 1'b1};
			end else begin
				mrem_q <= mtry;
				msum_q <= {msum_q[SumW-2:0], 1'b0};
			end
			mcnt_q <= mcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr_step) begin
			count_mem[clr_q[BinW-1:0]] <= '0;
			sum_mem[clr_q[BinW-1:0]]   <= '0;
		end else if (ctrl.mem_wr) begin
			count_mem[bin_q] <= cnt_new_q;
			sum_mem[bin_q]   <= sum_new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			low_q  <= BinW'(NumBins - 1);
			high_q <= '0;
		end else begin
			if (ctrl.clr_start) begin
				clr_q  <= '0;
				low_q  <= BinW'(NumBins - 1);
				high_q <= '0;
			end else if (ctrl.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctrl.mem_wr) begin
				if (bin_q < low_q) low_q <= bin_q;
				if (bin_q > high_q) high_q <= bin_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result.status      <= stat.is_read ? (range_q ? StOk : StAbove)
					: (stat.is_add ? st_q : StOk);
			result.bin_index   <= stat.is_read ? beat_q.read_bin
					: ((stat.is_add && st_q == StAbove) ? 11'(NumBins - 1)
					: ((stat.is_add && st_q == StOk && range_q) ? 11'(bin_q) : 11'd0));
			result.bin_count   <= (range_q && (stat.is_read || (stat.is_add && st_q == StOk)))
					? cnt_new_q : '0;
			result.mean_square <= (range_q && cnt_new_q != '0
					&& (stat.is_read || (stat.is_add && st_q == StOk)))
					? msum_q[MeanW-1:0] : '0;
			result.lowest_bin  <= 11'(low_q);
			result.highest_bin <= 11'(high_q);
		end
	end
endmodule

/* hw/rtl/dbsh_ctrl.sv */
// Controller: sequences clear sweep, binning division, store update and mean division.
module dbsh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dbsh_pkg::stat_t stat,
	output dbsh_pkg::ctrl_t ctrl
);
	import dbsh_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CLR   = 10'b0000000010,
		S_DIV   = 10'b0000000100,
		S_CLASS = 10'b0000001000,
		S_RD    = 10'b0000010000,
		S_MSTA  = 10'b0000100000,
		S_MEAN  = 10'b0001000000,
		S_WR    = 10'b0010000000,
		S_EMIT  = 10'b0100000000,
		S_INIT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_emit;
	// mean division starts in the cycle after the read is issued, when the read data is registered
	logic   mean_go_q;

	assign out_valid = out_valid_q;
	assign can_emit  = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_INIT: begin
				ctrl.clr_step = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = S_CLASS;
				end
			end
			S_CLASS: begin
				if (stat.is_clear) begin
					ctrl.clr_start = 1'b1;
					state_d        = S_CLR;
				end else if (stat.is_add && stat.need_div) begin
					ctrl.div_start = 1'b1;
					state_d        = S_DIV;
				end else if (stat.is_read) begin
					state_d = S_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_CLR: begin
				ctrl.clr_step = 1'b1;
				if (stat.clr_done) state_d = S_EMIT;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_done) state_d = S_RD;
			end
			S_RD: begin
				if (stat.is_add) ctrl.classify = 1'b1;
				state_d = S_MSTA;
			end
			S_MSTA: begin
				if (stat.in_range) begin
					ctrl.mem_rd = 1'b1;
					state_d     = S_MEAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_MEAN: begin
				ctrl.mean_step = 1'b1;
				if (stat.mean_done) state_d = S_WR;
			end
			S_WR: begin
				if (stat.is_add) ctrl.mem_wr = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (can_emit) begin
					ctrl.emit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
			mean_go_q   <= 1'b0;
		end else begin
			state_q   <= (mean_go_q) ? S_MEAN : state_d;
			mean_go_q <= ctrl.mem_rd;
			if (ctrl.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

/* hw/rtl/dbsh_mean_gate.sv */
// Mean start gate: turns the registered store read into the mean-division start pulse.
module dbsh_mean_gate (
	input  logic            clk,
	input  logic            arst_n,
	input  dbsh_pkg::ctrl_t ctrl_in,
	output dbsh_pkg::ctrl_t ctrl_out
);
	import dbsh_pkg::*;

	logic rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= 1'b0;
		else         rd_q <= ctrl_in.mem_rd;
	end

	always_comb begin
		ctrl_out            = ctrl_in;
		ctrl_out.mean_start = rd_q;
		ctrl_out.mean_step  = ctrl_in.mean_step && !rd_q;
	end
endmodule

/* hw/rtl/difference_binned_square_histogram.sv */
// Top level: histogram engine binning wave-number differences and summing squared amplitudes.
//
// Input channel in carries one command beat: clear, add sample or read bin.
// Output channel out returns exactly one result beat per command.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
// index 0 is the bin span, index 1 is near_zero_threshold.
// One command is in flight at a time; in.ready is high only while idle.
// After a beat is accepted, an in-range add goes through decode, the binning
// divider steps, bin classification, store read, the mean divider start and
// steps, write-back and output load; a read skips the binning divider and the
// write-back; an out-of-range add ends after bin classification; a skipped add
// or unused command goes from decode to output load; a clear sweeps all 2048
// store entries. The next beat is taken in the cycle after the result is loaded.
// A result waits in the output register while out.ready is low; the next
// command is still taken and holds its own result until that register frees.
// Reset sets the bin span to 1311, the threshold to 0 and the bin marks to
// their empty values, then sweeps all 2048 store entries to zero before
// in.ready rises.
module difference_binned_square_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	dbsh_in_if.sink                       in,
	dbsh_out_if.source                    out,
	input  logic                          cfg_we,
	input  logic [dbsh_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dbsh_pkg::CfgW-1:0]     cfg_wdata
);
	import dbsh_pkg::*;

	logic [CfgW-1:0] bin_span_q;
	logic [CfgW-1:0] threshold_q;
	ctrl_t           ctrl_raw;
	ctrl_t           ctrl;
	stat_t           stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_span_q  <= CfgW'(1311);
			threshold_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegBinWidth:  bin_span_q  <= cfg_wdata;
				RegThreshold: threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dbsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.stat      (stat),
		.ctrl      (ctrl_raw)
	);

	dbsh_mean_gate u_gate (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_raw),
		.ctrl_out (ctrl)
	);

	dbsh_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_data   (in.data),
		.bin_span  (bin_span_q),
		.threshold (threshold_q),
		.result    (out.data)
	);
endmodule
